// ===== rtl/core/thermistor_peak_temperature_macros.svh =====
// Assertion macros for the thermistor peak-temperature block.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef THERMISTOR_PEAK_TEMPERATURE_MACROS_SVH
`define THERMISTOR_PEAK_TEMPERATURE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tpt_pkg.sv =====
// Shared types and constants for the thermistor peak-temperature block.
// No dependencies.
package tpt_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW_FRAMES = 2'd0;
  localparam logic [1:0] CFG_SERIES_OHMS   = 2'd1;
  localparam logic [1:0] CFG_CAL_LEVEL     = 2'd2;
  localparam logic [1:0] CFG_OFFSET_OHMS   = 2'd3;

  localparam int CFG_DATA_W = 20;

  // Fixed-point constants
  localparam int          TROUGH_RESET = 8000;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [32:0] COEF_A       = 33'd6935460000;
  localparam logic [30:0] COEF_B       = 31'd2011390000;
  localparam logic [19:0] COEF_C       = 20'd933821;
  localparam logic [53:0] KELVIN_NUM   = 54'd16000000000000000;
  localparam logic signed [18:0] ZERO_C_HUNDREDTHS = 19'sd27315;
  localparam logic [17:0] DIV100_K     = 18'd167773;   // ceil(2^24 / 100)
  localparam logic signed [10:0] TEMP_MAX = 11'sd1000;
  localparam logic signed [10:0] TEMP_MIN = -11'sd300;

  // Shared divider widths and the squaring round count
  localparam int DIVN_W    = 54;
  localparam int DIVD_W    = 41;
  localparam int SQ_ROUNDS = 24;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PEAK_ZERO = 2'd1,
    ST_RES_NPOS  = 2'd2,
    ST_DEN_NPOS  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DIV1, S_DIV1W, S_SUB, S_RCHK, S_NORM, S_SQA, S_SQB,
    S_LNA, S_LNB, S_L2, S_L3, S_DT, S_DS, S_DCHK, S_DIV2W, S_TA, S_TB, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_MUL_NUM, OP_DIV_R, OP_SUB_R, OP_NORM_LOAD, OP_SHIFT, OP_M_LOAD,
    OP_SQ_MUL, OP_SQ_STEP, OP_LN_MUL, OP_LN_RND, OP_L2, OP_L3, OP_DTERMS,
    OP_DSUM, OP_DIV_H, OP_T_MUL, OP_T_FIN, OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    logic    accept;
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic report_due;
    logic peak_zero;
    logic r_nonpos;
    logic norm_top;
    logic d_zero;
    logic div_done;
  } flags_t;

endpackage

// ===== rtl/core/tpt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on tpt_pkg.
module tpt_div import tpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] dvs;
  logic [DIVN_W-1:0] quo;
  logic [CNT_W-1:0]  count;
  logic [DIVD_W:0]   shifted;
  logic              ge;

  // trial subtract
  assign shifted = {rem, quo[DIVN_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(DIVN_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= ge ? DIVD_W'(shifted - {1'b0, dvs}) : shifted[DIVD_W-1:0];
      quo <= {quo[DIVN_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/tpt_dp.sv =====
// Datapath: sample tracking, configuration, and the temperature arithmetic.
// Depends on tpt_pkg and tpt_div.
module tpt_dp import tpt_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output flags_t                        flags,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          frame_end,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic signed [10:0]            temp_celsius,
  output logic [1:0]                    status,
  output logic [14:0]                   peak_level,
  output logic signed [15:0]            trough_level
);

  localparam int TW = (SAMPLE_BITS > 14) ? SAMPLE_BITS : 14;

  // configuration
  logic [15:0] window_frames;
  logic [19:0] series_ohms;
  logic [14:0] cal_level;
  logic [19:0] offset_ohms;

  // tracking state
  logic signed [SAMPLE_BITS-1:0] frame_peak, window_peak, conv_peak;
  logic signed [TW-1:0]          frame_trough, window_trough, snap_trough;
  logic [15:0]                   frame_counter;

  // conversion working registers
  logic [34:0]        num;
  logic signed [35:0] rr;
  logic [34:0]        x;
  logic [5:0]         e;
  logic [30:0]        m;
  logic [61:0]        sq;
  logic [23:0]        frac;
  logic [61:0]        lprod;
  logic [28:0]        l;
  logic [57:0]        l2p;
  logic [62:0]        l3p;
  logic [59:0]        bl;
  logic [57:0]        cl;
  logic [40:0]        d;
  logic               t_neg;
  logic [35:0]        tprod;
  logic signed [10:0] temp_res;

  logic                 div_start, div_done;
  logic [DIVN_W-1:0]    div_dividend, div_quotient;
  logic [DIVD_W-1:0]    div_divisor;

  logic signed [SAMPLE_BITS-1:0] fp_new, wp_base;
  logic signed [TW-1:0]          ft_new, wt_base, sample_t;
  logic [15:0]                   cnt_base;
  logic                          due;
  logic [31:0]                   m_sq;
  logic [61:0]                   lsum;
  logic [60:0]                   dsum;
  logic signed [18:0]            hv, hmag;
  logic signed [12:0]            ts;
  logic signed [31:0]            peak_ext, trough_ext;

  // frame and window merge
  always_comb begin
    sample_t = TW'(sample);
    fp_new   = (sample > frame_peak) ? sample : frame_peak;
    ft_new   = (sample_t < frame_trough) ? sample_t : frame_trough;
    due      = frame_counter >= window_frames;
    wp_base  = due ? '0 : window_peak;
    wt_base  = due ? TW'(TROUGH_RESET) : window_trough;
    cnt_base = due ? '0 : frame_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_peak    <= '0;
      frame_trough  <= TW'(TROUGH_RESET);
      window_peak   <= '0;
      window_trough <= TW'(TROUGH_RESET);
      frame_counter <= '0;
    end else if (cmd.accept) begin
      if (frame_end) begin
        window_peak   <= (fp_new > wp_base) ? fp_new : wp_base;
        window_trough <= (ft_new < wt_base) ? ft_new : wt_base;
        frame_counter <= (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 1'b1;
        frame_peak    <= '0;
        frame_trough  <= TW'(TROUGH_RESET);
      end else begin
        frame_peak   <= fp_new;
        frame_trough <= ft_new;
      end
    end
  end

  // snapshot of the window being reported
  always_ff @(posedge clk) begin
    if (cmd.accept && frame_end && due) begin
      conv_peak   <= window_peak;
      snap_trough <= window_trough;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames <= 16'd100;
      series_ohms   <= 20'd10000;
      cal_level     <= 15'd2508;
      offset_ohms   <= 20'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_FRAMES: window_frames <= cfg_data[15:0];
        CFG_SERIES_OHMS:   series_ohms   <= cfg_data[19:0];
        CFG_CAL_LEVEL:     cal_level     <= cfg_data[14:0];
        CFG_OFFSET_OHMS:   offset_ohms   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // shared divider
  assign div_start    = (cmd.op == OP_DIV_R) || (cmd.op == OP_DIV_H);
  assign div_dividend = (cmd.op == OP_DIV_H) ? KELVIN_NUM : DIVN_W'(num);
  assign div_divisor  = (cmd.op == OP_DIV_H) ? d : DIVD_W'($unsigned(conv_peak));

  tpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // helper terms for the arithmetic steps
  always_comb begin
    m_sq = sq[61:30];
    lsum = lprod + (62'(1) << 31);
    dsum = (61'(COEF_A) << 24) + 61'(bl) + 61'(cl);
    hv   = $signed({1'b0, div_quotient[17:0]}) - ZERO_C_HUNDREDTHS;
    hmag = hv[18] ? -hv : hv;
    ts   = t_neg ? -$signed({1'b0, tprod[35:24]}) : $signed({1'b0, tprod[35:24]});
  end

  // arithmetic sequence, one step per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL_NUM:   num   <= 35'(series_ohms) * 35'(cal_level);
      OP_SUB_R:     rr    <= $signed({1'b0, div_quotient[34:0]})
                             - $signed(36'(series_ohms) + 36'(offset_ohms));
      OP_NORM_LOAD: begin
        x <= rr[34:0];
        e <= 6'd34;
      end
      OP_SHIFT: begin
        x <= {x[33:0], 1'b0};
        e <= e - 1'b1;
      end
      OP_M_LOAD: begin
        m    <= x[34:4];
        frac <= '0;
      end
      OP_SQ_MUL:    sq    <= 62'(m) * 62'(m);
      OP_SQ_STEP: begin
        m    <= m_sq[31] ? m_sq[31:1] : m_sq[30:0];
        frac <= {frac[22:0], m_sq[31]};
      end
      OP_LN_MUL:    lprod <= 62'({e, frac}) * 62'(LN2_Q32);
      OP_LN_RND:    l     <= lsum[60:32];
      OP_L2:        l2p   <= 58'(l) * 58'(l);
      OP_L3:        l3p   <= 63'(l2p[57:24]) * 63'(l);
      OP_DTERMS: begin
        bl <= 60'(COEF_B) * 60'(l);
        cl <= 58'(COEF_C) * 58'(l3p[61:24]);
      end
      OP_DSUM:      d     <= dsum[60:20];
      OP_T_MUL: begin
        t_neg <= hv[18];
        tprod <= 36'(hmag[17:0]) * 36'(DIV100_K);
      end
      OP_T_FIN: begin
        if (ts > 13'(TEMP_MAX))      temp_res <= TEMP_MAX;
        else if (ts < 13'(TEMP_MIN)) temp_res <= TEMP_MIN;
        else                         temp_res <= ts[10:0];
      end
      default: ;
    endcase
  end

  // output register
  assign peak_ext   = 32'(conv_peak);
  assign trough_ext = 32'(snap_trough);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_OUT) begin
      temp_celsius <= (cmd.code == ST_OK) ? temp_res : '0;
      status       <= cmd.code;
      peak_level   <= peak_ext[14:0];
      trough_level <= trough_ext[15:0];
    end
  end

  // status to the controller
  always_comb begin
    flags.report_due = due;
    flags.peak_zero  = conv_peak <= 0;
    flags.r_nonpos   = rr <= 0;
    flags.norm_top   = x[34];
    flags.d_zero     = d == '0;
    flags.div_done   = div_done;
  end

endmodule

// ===== rtl/core/tpt_ctrl.sv =====
// Controller state machine: sequences the conversion and owns the handshakes.
// Depends on tpt_pkg and the assertion macro header.
`include "thermistor_peak_temperature_macros.svh"
module tpt_ctrl import tpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   frame_end,
  output logic   out_valid,
  input  logic   out_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  localparam int RND_W = $clog2(SQ_ROUNDS);

  state_t           state, state_next;
  status_t          code, code_next;
  logic [RND_W-1:0] rnd, rnd_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= ST_OK;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    code_next  = code;
    rnd_next   = rnd;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    cmd.code   = code;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && frame_end && flags.report_due) state_next = S_CHK;
      end
      S_CHK: begin
        if (flags.peak_zero) begin
          code_next  = ST_PEAK_ZERO;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_MUL_NUM;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.op     = OP_DIV_R;
        state_next = S_DIV1W;
      end
      S_DIV1W: if (flags.div_done) state_next = S_SUB;
      S_SUB: begin
        cmd.op     = OP_SUB_R;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (flags.r_nonpos) begin
          code_next  = ST_RES_NPOS;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_NORM_LOAD;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (flags.norm_top) begin
          cmd.op     = OP_M_LOAD;
          rnd_next   = '0;
          state_next = S_SQA;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_SQA: begin
        cmd.op     = OP_SQ_MUL;
        state_next = S_SQB;
      end
      S_SQB: begin
        cmd.op   = OP_SQ_STEP;
        rnd_next = rnd + 1'b1;
        state_next = (rnd == RND_W'(SQ_ROUNDS - 1)) ? S_LNA : S_SQA;
      end
      S_LNA: begin
        cmd.op     = OP_LN_MUL;
        state_next = S_LNB;
      end
      S_LNB: begin
        cmd.op     = OP_LN_RND;
        state_next = S_L2;
      end
      S_L2: begin
        cmd.op     = OP_L2;
        state_next = S_L3;
      end
      S_L3: begin
        cmd.op     = OP_L3;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.op     = OP_DTERMS;
        state_next = S_DS;
      end
      S_DS: begin
        cmd.op     = OP_DSUM;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (flags.d_zero) begin
          code_next  = ST_DEN_NPOS;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_DIV_H;
          state_next = S_DIV2W;
        end
      end
      S_DIV2W: if (flags.div_done) state_next = S_TA;
      S_TA: begin
        cmd.op     = OP_T_MUL;
        state_next = S_TB;
      end
      S_TB: begin
        cmd.op     = OP_T_FIN;
        code_next  = ST_OK;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_LOAD_OUT;
          code_next  = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    if (cmd.op == OP_LOAD_OUT) out_valid_next = 1'b1;
    else if (out_ready)        out_valid_next = 1'b0;
    else                       out_valid_next = out_valid;
  end

  `TPT_ASSERT_IMPLY(a_div_done_in_wait, flags.div_done, state == S_DIV1W || state == S_DIV2W, "divider finished outside a wait state")
  `TPT_ASSERT_NEXT(a_report_starts, in_valid && in_ready && frame_end && flags.report_due, state == S_CHK, "report frame did not start a conversion")
  `TPT_ASSERT_NEXT(a_fin_holds, state == S_FIN && out_valid && !out_ready, state == S_FIN && out_valid, "result lost while output stalled")

endmodule

// ===== rtl/core/thermistor_peak_temperature.sv =====
// Top level of the thermistor peak-temperature block.
// Depends on tpt_pkg, tpt_ctrl and tpt_dp.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid / in_ready | sample, frame_end
//  result   | out_valid/out_ready | temp_celsius, status, peak_level, trough_level
//  config   | cfg_we              | cfg_index, cfg_data
//
// A sample that does not close a reporting frame leaves the block ready for the next one.
// A reporting frame end starts a conversion that holds off input: up to two passes of the
// shared restoring divider, up to 34 normalising shifts and 24 squaring rounds.
// The result sits in an output register, so input resumes while it waits.
// Reset is synchronous and active high; configuration returns to its defaults.
module thermistor_peak_temperature import tpt_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          frame_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [10:0]            temp_celsius,
  output logic [1:0]                    status,
  output logic [14:0]                   peak_level,
  output logic signed [15:0]            trough_level,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t   cmd;
  flags_t flags;

  tpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  tpt_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .sample       (sample),
    .frame_end    (frame_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .temp_celsius (temp_celsius),
    .status       (status),
    .peak_level   (peak_level),
    .trough_level (trough_level)
  );

endmodule

// ===== tb/thermistor_peak_temperature_tb.sv =====
// Self-checking testbench for thermistor_peak_temperature.
// Depends on tpt_pkg and the RTL top level; a directed table is followed by
// randomised frames across several register settings, checked by a local model.
`timescale 1ns / 1ps

module thermistor_peak_temperature_tb;
  import tpt_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [10:0] temp;
    status_t            st;
    logic [14:0]        peak;
    logic signed [15:0] trough;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               fe;
    logic               typed;
    status_t            st;
    logic [14:0]        peak;
    logic signed [15:0] trough;
  } row_t;

  // Directed rows; typed rows carry a reading worked out by hand
  localparam int N_ROWS = 14;
  localparam row_t DIR_ROWS [0:N_ROWS-1] = '{
    '{16'sd0,      1'b1, 1'b1, ST_PEAK_ZERO, 15'd0,     16'sd8000},
    '{-16'sd32768, 1'b1, 1'b1, ST_PEAK_ZERO, 15'd0,     16'sd0},
    '{16'sd32767,  1'b1, 1'b1, ST_PEAK_ZERO, 15'd0,     -16'sd32768},
    '{16'sd100,    1'b0, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{16'sd200,    1'b1, 1'b1, ST_RES_NPOS,  15'd32767, 16'sd8000},
    '{16'sd1,      1'b1, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{16'sd5000,   1'b0, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{-16'sd5,     1'b0, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{16'sd8001,   1'b1, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{-16'sd1,     1'b1, 1'b1, ST_RES_NPOS,  15'd8001,  -16'sd5},
    '{16'sd2508,   1'b1, 1'b1, ST_PEAK_ZERO, 15'd0,     -16'sd1},
    '{16'sd2507,   1'b1, 1'b1, ST_RES_NPOS,  15'd2508,  16'sd2508},
    '{16'sd1254,   1'b1, 1'b0, ST_OK,        15'd0,     16'sd0},
    '{-16'sd300,   1'b1, 1'b0, ST_OK,        15'd0,     16'sd0}
  };

  localparam int DRAIN_CYCLES = 400;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [15:0]    sample;
  logic                  frame_end;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [10:0]    temp_celsius;
  logic [1:0]            status;
  logic [14:0]           peak_level;
  logic signed [15:0]    trough_level;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  thermistor_peak_temperature u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .temp_celsius(temp_celsius),
    .status(status), .peak_level(peak_level), .trough_level(trough_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of registers and window state
  int unsigned m_frames, m_series, m_cal, m_offset;
  int          m_fpeak, m_ftrough, m_wpeak, m_wtrough;
  int unsigned m_count;

  reading_t pending_readings [$];
  int       errors;
  bit       calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Natural log of r in Q24, by repeated squaring
  function automatic u64_t ln_q24(u64_t r);
    u64_t m, frac, lg2;
    int e;
    frac = 0;
    e = 0;
    while (e < 63 && (r >> (e + 1)) != 0) e++;
    if (e <= 30) m = r << (30 - e);
    else m = r >> (e - 30);
    for (int i = 0; i < SQ_ROUNDS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg2 = (u64_t'(e) << 24) | frac;
    return (lg2 * 64'd2977044472 + (64'd1 << 31)) >> 32;
  endfunction

  // Window peak to reading
  function automatic reading_t peak_to_reading(int pk, int tr);
    reading_t rd;
    longint r, t;
    u64_t l, l2, l3, d, h;
    rd.temp = '0;
    rd.peak = pk[14:0];
    rd.trough = tr[15:0];
    if (pk <= 0) begin
      rd.st = ST_PEAK_ZERO;
      return rd;
    end
    r = longint'((u64_t'(m_series) * u64_t'(m_cal)) / u64_t'(pk))
        - (longint'(m_series) + longint'(m_offset));
    if (r <= 0) begin
      rd.st = ST_RES_NPOS;
      return rd;
    end
    l = ln_q24(u64_t'(r));
    l2 = (l * l) >> 24;
    l3 = (l2 * l) >> 24;
    d = ((64'd6935460000 << 24) + 64'd2011390000 * l + 64'd933821 * l3) >> 20;
    if (d == 0) begin
      rd.st = ST_DEN_NPOS;
      return rd;
    end
    h = 64'd16000000000000000 / d;
    t = (longint'(h) - 27315) / 100;
    if (t > 1000) t = 1000;
    if (t < -300) t = -300;
    rd.temp = t[10:0];
    rd.st = ST_OK;
    return rd;
  endfunction

  // Track extremes for one accepted sample; returns 1 with a reading at a report
  function automatic bit track_sample(logic signed [15:0] smp, logic fe, output reading_t rd);
    int s;
    bit due;
    s = smp;
    due = 1'b0;
    rd = '0;
    if (s > m_fpeak) m_fpeak = s;
    if (s < m_ftrough) m_ftrough = s;
    if (!fe) return 1'b0;
    if (m_count >= m_frames) begin
      rd = peak_to_reading(m_wpeak, m_wtrough);
      due = 1'b1;
      m_count = 0;
      m_wpeak = 0;
      m_wtrough = TROUGH_RESET;
    end
    if (m_fpeak > m_wpeak) m_wpeak = m_fpeak;
    if (m_ftrough < m_wtrough) m_wtrough = m_ftrough;
    if (m_count < 32'hFFFF) m_count++;
    m_fpeak = 0;
    m_ftrough = TROUGH_RESET;
    return due;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Present one sample and wait for its transfer; called at a rising edge
  task automatic send_sample(logic signed [15:0] smp, logic fe, output bit due,
                             output reading_t rd);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= smp;
    frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    due = track_sample(smp, fe, rd);
  endtask

  // Write enable is left high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_WINDOW_FRAMES: m_frames = val & 32'hFFFF;
      CFG_SERIES_OHMS:   m_series = val & 32'hFFFFF;
      CFG_CAL_LEVEL:     m_cal    = val & 32'h7FFF;
      CFG_OFFSET_OHMS:   m_offset = val & 32'hFFFFF;
      default: ;
    endcase
  endtask

  // Sender holds off until every reading is in and the core has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(1, 3000));
      4:          return 16'($urandom_range(1, 300));
      5:          return 16'($urandom);
      6:          return -16'sd1 - 16'($urandom_range(0, 32767));
      7:          return 16'sd0;
      8:          return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      default:    return 16'($urandom_range(3000, 32767));
    endcase
  endfunction

  // Result side: random stalls and comparison against the oldest reading
  int stall_left;
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          report("unexpected transfer, temp", temp_celsius, 0);
        end else begin
          want = pending_readings.pop_front();
          if (status != want.st) report("status", status, want.st);
          if (temp_celsius != want.temp) report("temp_celsius", temp_celsius, want.temp);
          if (peak_level != want.peak) report("peak_level", peak_level, want.peak);
          if (trough_level != want.trough) report("trough_level", trough_level, want.trough);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 18) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #60ms;
    $display("thermistor_peak_temperature verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_cfg [0:9][0:3];
    int          phase_items;
    int          sent;
    int          len;
    bit          due;
    reading_t    rd;

    in_valid  = 1'b0;
    sample    = '0;
    frame_end = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    errors    = 0;
    calm      = 1'b0;
    m_frames = 100; m_series = 10000; m_cal = 2508; m_offset = 0;
    m_fpeak = 0; m_ftrough = TROUGH_RESET; m_wpeak = 0; m_wtrough = TROUGH_RESET;
    m_count = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: report at every frame end
    write_reg(CFG_WINDOW_FRAMES, 0);
    cfg_we <= 1'b0;
    for (int i = 0; i < N_ROWS; i++) begin
      send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].fe, due, rd);
      if (due) begin
        if (DIR_ROWS[i].typed) begin
          rd.st = DIR_ROWS[i].st;
          rd.temp = '0;
          rd.peak = DIR_ROWS[i].peak;
          rd.trough = DIR_ROWS[i].trough;
        end
        pending_readings.push_back(rd);
      end
    end
    drain();

    // Register settings per phase: window_frames, series, cal, offset
    phase_cfg[0] = '{0, 10000, 2508, 0};
    phase_cfg[1] = '{3, 1000000, 32767, 0};
    phase_cfg[2] = '{1, 1, 1, 0};
    phase_cfg[3] = '{2, 0, 2508, 0};
    phase_cfg[4] = '{5, 10000, 0, 0};
    phase_cfg[5] = '{4, 1000000, 32767, 1000000};
    phase_cfg[6] = '{65535, 10000, 2508, 0};
    phase_cfg[7] = '{$urandom_range(0, 6), $urandom_range(1, 1000000),
                     $urandom_range(1, 32767), $urandom_range(0, 20000)};
    phase_cfg[8] = '{0, 500000, 20000, 300000};
    phase_cfg[9] = '{2, 10000, 2508, 500};

    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_WINDOW_FRAMES, phase_cfg[p][0]);
      write_reg(CFG_SERIES_OHMS, phase_cfg[p][1]);
      write_reg(CFG_CAL_LEVEL, phase_cfg[p][2]);
      write_reg(CFG_OFFSET_OHMS, phase_cfg[p][3]);
      cfg_we <= 1'b0;
      if (p == 9) calm = 1'b1;
      phase_items = (p == 6) ? 40 : 110;
      sent = 0;
      while (sent < phase_items) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_sample(pick_sample(), (k == len - 1), due, rd);
          if (due) pending_readings.push_back(rd);
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("thermistor_peak_temperature verification clean");
    end else begin
      $display("thermistor_peak_temperature verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tpt_pkg.sv
rtl/core/tpt_div.sv
rtl/core/tpt_dp.sv
rtl/core/tpt_ctrl.sv
rtl/core/thermistor_peak_temperature.sv
tb/thermistor_peak_temperature_tb.sv
